@@ rtl/core/rdc_pkg.sv @@
// Shared types, constants and helpers for the radix digit converter.
// Used by rdc_cell and radix_digit_converter_top; no dependencies.
package rdc_pkg;

  // Width of the converted value and of the digit chain
  localparam int VALUE_WIDTH = 31;
  localparam int NUM_CELLS   = VALUE_WIDTH;

  // Fixed field widths of the stream words
  localparam int VALUE_FIELD_W = 31;
  localparam int RADIX_W       = 5;
  localparam int IN_TDATA_W    = 40;
  localparam int CHAR_W        = 7;
  localparam int OUT_TDATA_W   = 8;
  localparam int DIGIT_W       = 4;

  // Counter widths
  localparam int CNT_W = $clog2(VALUE_WIDTH + NUM_CELLS);
  localparam int REM_W = $clog2(NUM_CELLS + 1);

  // Radix limits and character codes
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 5'd16;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 7'd65;
  localparam logic [DIGIT_W-1:0] FIRST_LETTER = 4'd10;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic               clear;
    logic               convert;
    logic               shift;
    logic [RADIX_W-1:0] radix;
  } cell_ctrl_t;

  // Map a digit value to its ASCII character
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ch;
    if (d < FIRST_LETTER) begin
      ch = CHAR_ZERO + {3'b000, d};
    end else begin
      ch = CHAR_LETTER_A + {3'b000, d - FIRST_LETTER};
    end
    return ch;
  endfunction

endpackage

@@ rtl/core/rdc_cell.sv @@
// One digit cell of the conversion chain: doubles its digit and adds the
// incoming carry modulo the radix, or shifts its digit up for readout.
// Depends on rdc_pkg.
module rdc_cell
  import rdc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cell_ctrl_t         ctrl,
  input  logic               v_in,
  input  logic               c_in,
  input  logic [DIGIT_W-1:0] d_in,
  output logic               v_out,
  output logic               c_out,
  output logic [DIGIT_W-1:0] d_out
);

  logic [DIGIT_W-1:0] d_r, d_nxt;
  logic               c_r;
  logic               v_r;
  logic [RADIX_W-1:0] sum;
  logic [RADIX_W-1:0] diff;
  logic               ge;

  // Double the digit, add the carry, reduce once by the radix
  always_comb begin
    sum  = {d_r, c_in};
    ge   = (sum >= ctrl.radix);
    diff = sum - ctrl.radix;
    d_nxt = ge ? diff[DIGIT_W-1:0] : sum[DIGIT_W-1:0];
  end

  // Valid token travels with the carry to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ctrl.convert) begin
      v_r <= v_in;
    end else begin
      v_r <= 1'b0;
    end
  end

  // Digit and carry update
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      d_r <= '0;
      c_r <= 1'b0;
    end else if (ctrl.convert && v_in) begin
      d_r <= d_nxt;
      c_r <= ge;
    end else if (ctrl.shift) begin
      d_r <= d_in;
    end
  end

  assign v_out = v_r;
  assign c_out = c_r;
  assign d_out = d_r;

endmodule

@@ rtl/core/radix_digit_converter_top.sv @@
// Integer to base-N digit string converter: a chain of digit cells and
// its sequencer, with a registered output word. Depends on rdc_pkg, rdc_cell.
//
// Each input word carries a value and a radix (saturated to 2..16). The value
// bits enter the cell chain most significant first; each cell holds one digit
// and passes a registered carry to the next, so the chain settles once the
// last value bit has rippled through every cell. The chain then shifts upward,
// dropping leading zeros at one per cycle, and emits one ASCII character per
// cycle while the output is not stalled, most significant first, with tlast on
// the final one. The time from one accepted word to the next is set by the
// carry wavefront through the chain and the serial readout; output stalls add
// to this. A new word is accepted once the last character has entered the
// output register.
module radix_digit_converter_top
  import rdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: value [30:0], radix [35:31], zero pad [39:36]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: digit_char [6:0], zero pad [7]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_SKIP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [REM_W-1:0]       rem_r, rem_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [RADIX_W-1:0]     radix_r, radix_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]      out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   accept;
  logic                   out_free;
  logic                   feed_valid;
  logic [RADIX_W-1:0]     radix_in;
  cell_ctrl_t             ctrl;

  logic [DIGIT_W-1:0]     d_w [NUM_CELLS];
  logic                   v_w [NUM_CELLS];
  logic                   c_w [NUM_CELLS];
  logic [DIGIT_W-1:0]     top_digit;

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_free   = !out_valid_r || out_tready;
  assign feed_valid = (state_r == ST_CONV) && (cnt_r < CNT_W'(VALUE_WIDTH));
  assign top_digit  = d_w[NUM_CELLS-1];

  // Saturate the incoming radix
  always_comb begin
    radix_in = in_tdata[VALUE_FIELD_W +: RADIX_W];
    if (radix_in < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (radix_in > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    value_nxt     = value_r;
    radix_nxt     = radix_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl.clear    = 1'b0;
    ctrl.convert  = 1'b0;
    ctrl.shift    = 1'b0;
    ctrl.radix    = radix_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          value_nxt  = VALUE_WIDTH'(in_tdata[VALUE_FIELD_W-1:0]);
          radix_nxt  = radix_in;
          cnt_nxt    = '0;
          ctrl.clear = 1'b1;
          state_nxt  = ST_CONV;
        end
      end
      ST_CONV: begin
        // Feed one bit per cycle and let the carries ripple up the chain
        ctrl.convert = 1'b1;
        value_nxt    = {value_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(VALUE_WIDTH + NUM_CELLS - 2)) begin
          rem_nxt   = REM_W'(NUM_CELLS);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, keep at least one digit
        if (top_digit == '0 && rem_r > REM_W'(1)) begin
          ctrl.shift = 1'b1;
          rem_nxt    = rem_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Emit the top digit whenever the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = digit_to_ascii(top_digit);
          out_last_nxt  = (rem_r == REM_W'(1));
          ctrl.shift    = 1'b1;
          rem_nxt       = rem_r - 1'b1;
          if (rem_r == REM_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    value_r    <= value_nxt;
    radix_r    <= radix_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // Digit cell chain, least significant digit in cell 0
  genvar gi;
  generate
    for (gi = 0; gi < NUM_CELLS; gi++) begin : g_cell
      if (gi == 0) begin : g_first
        rdc_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .ctrl  (ctrl),
          .v_in  (feed_valid),
          .c_in  (value_r[VALUE_WIDTH-1]),
          .d_in  ({DIGIT_W{1'b0}}),
          .v_out (v_w[gi]),
          .c_out (c_w[gi]),
          .d_out (d_w[gi])
        );
      end else begin : g_next
        rdc_cell u_cell (
          .clk   (clk),
          .rst_n (rst_n),
          .ctrl  (ctrl),
          .v_in  (v_w[gi-1]),
          .c_in  (c_w[gi-1]),
          .d_in  (d_w[gi-1]),
          .v_out (v_w[gi]),
          .c_out (c_w[gi]),
          .d_out (d_w[gi])
        );
      end
    end
  endgenerate

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The chain is long enough: the top cell never overflows
  a_no_top_carry: assert property (@(posedge clk) disable iff (!rst_n)
    !(v_w[NUM_CELLS-1] && c_w[NUM_CELLS-1]))
    else $error("carry out of the top digit cell");

  // Every emitted word is a legal digit character
  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_char_r >= 7'd48 && out_char_r <= 7'd57) ||
                     (out_char_r >= 7'd65 && out_char_r <= 7'd70)))
    else $error("illegal digit character on output");

  // Readout starts on a nonzero digit unless only one is left
  a_no_leading_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && $past(state_r) == ST_SKIP && rem_r > REM_W'(1))
      |-> (top_digit != '0))
    else $error("leading zero reached readout");

  // Top digit stays below the radix while an item is in flight
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && $past(state_r) != ST_IDLE) |-> ({1'b0, top_digit} < radix_r))
    else $error("digit not below radix");
`endif

endmodule
